>>> rtl/lzsd_pkg.sv
// lzsd_pkg: shared types and constants of the lzss stream decoder
// no dependencies

package lzsd_pkg;

  localparam int RING_DEPTH    = 4096;
  localparam int RING_AW       = 12;
  localparam int FILL_W        = 13;
  localparam int LONGEST_MATCH = 18;
  localparam int LENGTH_BIAS   = 2;
  localparam int LEN_W         = 5;

  localparam logic [RING_AW-1:0] WP_START   = RING_AW'(RING_DEPTH - LONGEST_MATCH);
  localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(RING_DEPTH);
  localparam logic [7:0]         SPACE_BYTE = 8'h20;
  localparam logic [LEN_W-1:0]   LEN_ADD    = LEN_W'(LENGTH_BIAS + 1);

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  typedef struct packed {
    logic               lit;
    logic               copy;
    logic [7:0]         data;
    logic [RING_AW-1:0] pos;
    logic [3:0]         len_code;
  } lzsd_cmd_t;

endpackage

>>> rtl/lzsd_parse.sv
// lzsd_parse: flag byte and token parser, turns accepted beats into commands
// depends on lzsd_pkg

module lzsd_parse import lzsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] in_byte,
  output lzsd_cmd_t cmd
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] flag_bits;
  logic [3:0] flags_left;
  logic [7:0] pos_low;
  logic       item_done;

  always_comb begin
    cmd.lit      = accept && (phase == PH_ITEM) && flag_bits[0];
    cmd.copy     = accept && (phase == PH_LEN);
    cmd.data     = in_byte;
    cmd.pos      = {in_byte[7:4], pos_low};
    cmd.len_code = in_byte[3:0];
    item_done    = cmd.lit || cmd.copy;
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_ITEM: begin
        if (flag_bits[0]) begin
          phase_next = (flags_left <= 4'd1) ? PH_FLAG : PH_ITEM;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        phase_next = (flags_left <= 4'd1) ? PH_FLAG : PH_ITEM;
      end
      default: begin
        phase_next = PH_ITEM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      flag_bits  <= 8'd0;
      flags_left <= 4'd0;
      pos_low    <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PH_ITEM && !flag_bits[0]) begin
        pos_low <= in_byte;
      end
      if (item_done) begin
        flag_bits <= {1'b0, flag_bits[7:1]};
        if (flags_left != 4'd0) begin
          flags_left <= flags_left - 4'd1;
        end
      end else if (phase != PH_ITEM && phase != PH_LEN) begin
        flag_bits  <= in_byte;
        flags_left <= 4'd8;
      end
    end
  end

endmodule

>>> rtl/lzsd_ring.sv
// lzsd_ring: history ring memory, copy sequencer, read stage and output register
// depends on lzsd_pkg

module lzsd_ring import lzsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lzsd_cmd_t  cmd,
  output logic       can_take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  logic [7:0] mem [RING_DEPTH];
  logic [7:0] q;

  logic               copy_active;
  logic [RING_AW-1:0] src;
  logic [LEN_W-1:0]   left;

  logic       s1_valid;
  logic       s1_fwd;
  logic [7:0] s1_fbyte;
  logic       s1_filled;
  logic       s1_last;

  logic [RING_AW-1:0] wp;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;
  logic [RING_AW-1:0] src_off;

  logic       adv;
  logic       issue;
  logic [7:0] s1_byte;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign issue    = copy_active && (!s1_valid || adv);
  assign can_take = !copy_active && (!s1_valid || adv);
  assign s1_byte  = s1_fwd ? s1_fbyte : (s1_filled ? q : SPACE_BYTE);
  assign src_off  = src - WP_START;

  always_comb begin
    fill_next = fill;
    if (adv && fill != FILL_FULL) begin
      fill_next = fill + FILL_W'(1);
    end
  end

  // ring storage, read-old on a same-address collision, forwarded below
  always_ff @(posedge clk) begin
    if (adv) begin
      mem[wp] <= s1_byte;
    end
    if (issue) begin
      q <= mem[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_active <= 1'b0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      wp          <= WP_START;
      fill        <= '0;
    end else begin
      if (cmd.copy) begin
        copy_active <= 1'b1;
        src         <= cmd.pos;
        left        <= {1'b0, cmd.len_code} + LEN_ADD;
      end else if (issue) begin
        src  <= src + RING_AW'(1);
        left <= left - LEN_W'(1);
        if (left == LEN_W'(1)) begin
          copy_active <= 1'b0;
        end
      end

      priority if (issue) begin
        s1_valid  <= 1'b1;
        s1_fwd    <= adv && (src == wp);
        s1_fbyte  <= s1_byte;
        s1_filled <= {1'b0, src_off} < fill_next;
        s1_last   <= (left == LEN_W'(1));
      end else if (cmd.lit) begin
        s1_valid  <= 1'b1;
        s1_fwd    <= 1'b1;
        s1_fbyte  <= cmd.data;
        s1_filled <= 1'b1;
        s1_last   <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end

      if (adv) begin
        out_valid <= 1'b1;
        out_byte  <= s1_byte;
        run_last  <= s1_last;
        wp        <= wp + RING_AW'(1);
        fill      <= fill_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count past ring depth");

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    !(issue && cmd.lit))
    else $error("literal and copy read in the same cycle");

  a_copy_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.copy |-> !copy_active)
    else $error("copy started while one is running");

  a_copy_end: assert property (@(posedge clk) disable iff (rst)
    (issue && left == LEN_W'(1)) |=> !copy_active && s1_valid && s1_last)
    else $error("copy did not end on its last byte");

endmodule

>>> rtl/lzss_stream_decoder_unit.sv
// lzss_stream_decoder_unit: top level of the lzss stream decoder
// depends on lzsd_pkg, lzsd_parse, lzsd_ring
//
//   channel  | signals                       | beat
//   in       | in_valid, in_ready, in_byte   | one compressed byte
//   out      | out_valid, out_ready,         | one decompressed byte,
//            | out_byte, run_last            | run_last on the last of a token
//
// a length byte starts a copy of 3 to 18 bytes, one ring read per cycle
// through the single read port unless the output stalls, in_ready low meanwhile
// reset does not clear the ring: a fill count marks unwritten ring entries as spaces
// a stalled out beat freezes the ring; a full read stage then holds, in_ready low

module lzss_stream_decoder_unit import lzsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  lzsd_cmd_t cmd;
  logic      can_take;
  logic      accept;

  assign in_ready = can_take;
  assign accept   = in_valid && can_take;

  lzsd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .cmd     (cmd)
  );

  lzsd_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

endmodule

>>> tb/lzsd_decode_checker.sv
// lzsd_decode_checker: watches both channels of the lzss stream decoder, decodes
// every accepted compressed beat on its own and compares each decompressed beat
// depends on lzsd_pkg

module lzsd_decode_checker import lzsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  output int         mismatches,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } plain_byte_t;

  logic [7:0]         hist [0:RING_DEPTH-1];
  logic [RING_AW-1:0] wr_ptr;
  logic [7:0]         flags;
  logic [3:0]         flags_left;
  logic [1:0]         phase;
  logic [7:0]         pos_lo;
  plain_byte_t        decoded_fifo [$];
  plain_byte_t        want;

  task automatic next_flag();
    flags = flags >> 1;
    if (flags_left != 4'd0) flags_left = flags_left - 4'd1;
    phase = (flags_left == 4'd0) ? PH_FLAG : PH_ITEM;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [RING_AW-1:0] src;
    logic [LEN_W-1:0]   run_len;
    logic [7:0]         c;
    case (phase)
      PH_ITEM: begin
        if (flags[0]) begin
          hist[wr_ptr] = b;
          wr_ptr = wr_ptr + 1'b1;
          decoded_fifo.push_back(plain_byte_t'{b, 1'b1});
          next_flag();
        end else begin
          pos_lo = b;
          phase = PH_LEN;
        end
      end
      PH_LEN: begin
        src = {b[7:4], pos_lo};
        run_len = {1'b0, b[3:0]} + LEN_ADD;
        // copy one byte at a time so an overlapping run sees what it just wrote
        for (int i = 0; i < run_len; i++) begin
          c = hist[src];
          hist[wr_ptr] = c;
          wr_ptr = wr_ptr + 1'b1;
          src = src + 1'b1;
          decoded_fifo.push_back(plain_byte_t'{c, i == run_len - 1});
        end
        next_flag();
      end
      default: begin
        flags = b;
        flags_left = 4'd8;
        phase = PH_ITEM;
      end
    endcase
  endtask

  // sampled mid-cycle: a handshake seen here completes at the next rising edge
  always @(negedge clk) begin
    if (rst) begin
      for (int k = 0; k < RING_DEPTH; k++) hist[k] = SPACE_BYTE;
      wr_ptr = WP_START;
      flags = 8'd0;
      flags_left = 4'd0;
      phase = PH_FLAG;
      pos_lo = 8'd0;
      decoded_fifo.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte);
      if (out_valid && out_ready) begin
        if (decoded_fifo.size() == 0) begin
          $display("%0t: output beat with nothing expected: out_byte %02h run_last %0b",
                   $time, out_byte, run_last);
          mismatches++;
        end else begin
          want = decoded_fifo.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
            mismatches++;
          end
          if (run_last !== want.last) begin
            $display("%0t: run_last expected %0b actual %0b", $time, want.last, run_last);
            mismatches++;
          end
        end
      end
    end
    pending = decoded_fifo.size();
  end

endmodule

>>> tb/lzss_stream_decoder_unit_test.sv
// lzss_stream_decoder_unit_test: drives compressed streams of literals and copies
// into lzss_stream_decoder_unit with random gaps and stalls, verdict from the checker
// depends on lzsd_pkg, lzss_stream_decoder_unit, lzsd_decode_checker

module lzss_stream_decoder_unit_test;
  import lzsd_pkg::*;

  localparam int STUCK_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       run_last;

  int n_bad;
  int pending;
  int stuck_cycles = 0;
  int beats_sent = 0;
  int groups = 0;
  bit quiet = 1'b0;

  logic [RING_AW-1:0] wr_est;
  logic [RING_AW-1:0] copy_pos;
  logic [7:0]         flag_byte;

  lzss_stream_decoder_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .run_last (run_last)
  );

  lzsd_decode_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .mismatches(n_bad),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_pair(input logic [RING_AW-1:0] pos, input logic [3:0] code);
    send_byte(pos[7:0]);
    send_byte({pos[11:8], code});
    wr_est = wr_est + RING_AW'(code) + RING_AW'(LEN_ADD);
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(negedge clk);
    $display("lzss_stream_decoder_unit verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'd0;
    wr_est = WP_START;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // all literals, byte extremes
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h3C);
    wr_est = wr_est + RING_AW'(8);

    // all copies: untouched tail of the ring with wrap, start of ring,
    // overlapping runs, bytes the first copy wrote, longest and shortest
    send_byte(8'h00);
    send_pair(12'hFFA, 4'hF);
    send_pair(12'h000, 4'h0);
    send_pair(wr_est - 12'd1, 4'hF);
    send_pair(wr_est - 12'd3, 4'h7);
    send_pair(12'hFF6, 4'h2);
    send_pair(12'hFFF, 4'h9);
    send_pair(12'h800, 4'h1);
    send_pair(12'h5A5, 4'hA);

    while (beats_sent < 205) begin
      if (groups == 6) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      quiet = (beats_sent > 175) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       flag_byte = 8'h00;
        1:       flag_byte = 8'hFF;
        default: flag_byte = 8'($urandom);
      endcase
      send_byte(flag_byte);
      for (int k = 0; k < 8; k++) begin
        if (flag_byte[k]) begin
          send_byte(8'($urandom));
          wr_est = wr_est + 1'b1;
        end else begin
          if ($urandom_range(0, 3) == 0) copy_pos = RING_AW'($urandom);
          else copy_pos = wr_est - RING_AW'($urandom_range(1, 40));
          send_pair(copy_pos, 4'($urandom));
        end
      end
      groups++;
    end

    // stream ends inside a pair
    send_byte(8'h00);
    send_byte(8'h3C);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0 && pending == 0)
      $display("lzss_stream_decoder_unit verification clean");
    else
      $display("lzss_stream_decoder_unit verification failed");
    $finish;
  end

endmodule
